### src/sbe_pkg.sv
// Package for the seam backtrack engine: sizes, op codes, status codes.
// Used by every module in src; depends on nothing.
package sbe_pkg;
    localparam int MAX_ROWS = 512;
    localparam int MAX_COLUMNS = 512;
    localparam int ENERGY_BITS = 32;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int CELL_W = ROW_W + COL_W;
    localparam int CNT_W = 10;
    localparam int RETRY_MAX = 1023;

    localparam logic [2:0] OP_WRITE_ENERGY = 3'd0;
    localparam logic [2:0] OP_WRITE_POINTER = 3'd1;
    localparam logic [2:0] OP_CLEAR_MARKS = 3'd2;
    localparam logic [2:0] OP_FIND_SEAM = 3'd3;
    localparam logic [2:0] OP_READ_SEAM = 3'd4;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FOUND = 2'd1;
    localparam logic [1:0] STATUS_RECOMPUTE = 2'd2;

    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_COLUMN_COUNT = 1'b1;

    // Saturate a configured count to 1..maxv.
    function automatic logic [CNT_W:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W:0] maxv);
        logic [CNT_W:0] r;
        begin
            r = {1'b0, v};
            if (v == '0)
            begin
                r = {{CNT_W{1'b0}}, 1'b1};
            end
            else if ({1'b0, v} > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction
endpackage

### src/seam_backtrack_engine_top.sv
// Seam backtrack engine top level: command decode, sequencer and all memories.
// Depends on sbe_pkg.
//
// The block holds stall high while it works on an item and until the result,
// which waits in its own register, is taken. Writes and unused op codes go
// straight to the result; seam reads pass through a read state first. A find
// scans the bottom row one column a cycle, then traces the back pointers row by
// row (S_TRACE_RD, then S_TRACE_CHK). It repeats both on every collision. It
// then marks the seam row by row (read the mark row, then write it back).
// Clearing the marks sweeps the mark memory one row of MAX_COLUMNS bits a cycle
// over all MAX_ROWS rows before its result. After reset the same sweep, which
// also zeroes the stored seam, runs over all MAX_ROWS rows before the first
// item is taken.
// Unwritten energies and pointers read as undefined values.
module seam_backtrack_engine_top
    import sbe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             op,
    input  logic [8:0]             row,
    input  logic [8:0]             column,
    input  logic [31:0]            energy,
    input  logic [8:0]             pointer,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             status,
    output logic [8:0]             column_res,
    output logic [9:0]             retries,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [9:0]             cfg_data
);
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_SCAN_END = 4'd3;
    localparam logic [3:0] S_TRACE_RD = 4'd4;
    localparam logic [3:0] S_TRACE_CHK = 4'd5;
    localparam logic [3:0] S_COMMIT_RD = 4'd6;
    localparam logic [3:0] S_COMMIT_WR = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;
    localparam logic [3:0] S_READ = 4'd9;
    localparam logic [3:0] S_FAIL = 4'd10;
    localparam logic [3:0] S_WIPE = 4'd11;

    logic [3:0] state_reg, state_next;

    // Memories.
    logic [ENERGY_BITS-1:0] energy_mem [MAX_COLUMNS];
    logic [COL_W-1:0] ptr_mem [MAX_ROWS*MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] mark_mem [MAX_ROWS];
    logic [COL_W-1:0] seam_mem [MAX_ROWS];

    logic [CNT_W-1:0] row_count_reg, column_count_reg;
    logic [CNT_W:0] rows_eff, cols_eff;
    logic [ROW_W-1:0] bottom;

    logic [ROW_W-1:0] row_in_reg;
    logic [COL_W-1:0] col_in_reg;
    logic [ENERGY_BITS-1:0] energy_in_reg;
    logic row_ok_reg;

    logic [COL_W:0] scan_col_reg;
    logic [COL_W-1:0] scan_prev_reg;
    logic [ENERGY_BITS-1:0] best_reg;
    logic found_reg;
    logic [COL_W-1:0] start_reg;
    logic [ROW_W-1:0] r_reg;
    logic [COL_W-1:0] prev_reg;
    logic [9:0] retry_reg;
    logic [ROW_W:0] sweep_reg;

    // Registered memory read data.
    logic [ENERGY_BITS-1:0] e_rd;
    logic [MAX_COLUMNS-1:0] mark_rd;
    logic [COL_W-1:0] ptr_rd;
    logic [COL_W-1:0] seam_rd;

    logic [1:0] status_reg;
    logic [8:0] colres_reg;
    logic [9:0] retries_reg;

    // Memory control, decided combinationally from the state and the inputs.
    logic [ROW_W-1:0] mark_raddr;
    logic [CELL_W-1:0] ptr_raddr;
    logic [ROW_W-1:0] seam_addr;
    logic seam_we;
    logic [COL_W-1:0] seam_wdata;
    logic mark_we;
    logic [ROW_W-1:0] mark_waddr;
    logic [MAX_COLUMNS-1:0] mark_wdata;
    logic energy_we;
    logic [COL_W-1:0] energy_waddr;
    logic [ENERGY_BITS-1:0] energy_wdata;

    logic accept_in;
    logic [COL_W-1:0] cur;
    logic cur_bad;

    assign rows_eff = clamp_count(row_count_reg, (CNT_W+1)'(MAX_ROWS));
    assign cols_eff = clamp_count(column_count_reg, (CNT_W+1)'(MAX_COLUMNS));
    assign bottom = ROW_W'(rows_eff - 1'b1);

    assign in_stall = (state_reg != S_IDLE);
    assign accept_in = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_OUT);
    assign status = status_reg;
    assign column_res = colres_reg;
    assign retries = retries_reg;

    assign cur = ptr_rd;
    assign cur_bad = ({1'b0, cur} >= (COL_W+1)'(cols_eff)) || mark_rd[cur];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CNT_W'(512);
            column_count_reg <= CNT_W'(512);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT: row_count_reg <= cfg_data;
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mark_raddr = bottom;
        ptr_raddr = {r_reg, prev_reg};
        seam_addr = r_reg;
        seam_we = 1'b0;
        seam_wdata = cur;
        mark_we = 1'b0;
        mark_waddr = r_reg;
        mark_wdata = mark_rd;
        energy_we = 1'b0;
        energy_waddr = col_in_reg;
        energy_wdata = energy_in_reg;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                // The sweep after reset also zeroes the stored seam.
                mark_we = 1'b1;
                mark_waddr = sweep_reg[ROW_W-1:0];
                mark_wdata = '0;
                seam_we = 1'b1;
                seam_addr = sweep_reg[ROW_W-1:0];
                seam_wdata = '0;
                if (sweep_reg == (ROW_W+1)'(MAX_ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_WIPE:
            begin
                mark_we = 1'b1;
                mark_waddr = sweep_reg[ROW_W-1:0];
                mark_wdata = '0;
                if (sweep_reg == (ROW_W+1)'(MAX_ROWS - 1))
                begin
                    state_next = S_OUT;
                end
            end
            S_IDLE:
            begin
                // Start a seam read right away so the data is ready in S_READ.
                seam_addr = row;
                if (accept_in)
                begin
                    unique case (op)
                        OP_CLEAR_MARKS: state_next = S_WIPE;
                        OP_FIND_SEAM: state_next = S_SCAN;
                        OP_READ_SEAM: state_next = S_READ;
                        default: state_next = S_OUT;
                    endcase
                end
            end
            S_SCAN:
            begin
                if ({1'b0, scan_col_reg} == (COL_W+2)'(cols_eff))
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                if (!found_reg)
                begin
                    state_next = S_FAIL;
                end
                else
                begin
                    seam_we = 1'b1;
                    seam_addr = bottom;
                    seam_wdata = start_reg;
                    state_next = (bottom == '0) ? S_COMMIT_RD : S_TRACE_RD;
                end
            end
            S_TRACE_RD:
            begin
                mark_raddr = r_reg - 1'b1;
                state_next = S_TRACE_CHK;
            end
            S_TRACE_CHK:
            begin
                if (cur_bad)
                begin
                    energy_we = 1'b1;
                    energy_waddr = start_reg;
                    energy_wdata = '1;
                    state_next = S_SCAN;
                end
                else
                begin
                    seam_we = 1'b1;
                    seam_addr = r_reg - 1'b1;
                    seam_wdata = cur;
                    state_next = (r_reg == ROW_W'(1)) ? S_COMMIT_RD : S_TRACE_RD;
                end
            end
            S_COMMIT_RD:
            begin
                mark_raddr = r_reg;
                seam_addr = r_reg;
                state_next = S_COMMIT_WR;
            end
            S_COMMIT_WR:
            begin
                mark_we = 1'b1;
                mark_waddr = r_reg;
                mark_wdata = mark_rd | ({{(MAX_COLUMNS-1){1'b0}}, 1'b1} << seam_rd);
                state_next = (r_reg == bottom) ? S_OUT : S_COMMIT_RD;
            end
            S_READ:
            begin
                seam_addr = row_in_reg;
                state_next = S_OUT;
            end
            S_FAIL: state_next = S_OUT;
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE && accept_in && op == OP_WRITE_ENERGY
            && {1'b0, column} < 10'(MAX_COLUMNS))
        begin
            energy_we = 1'b1;
            energy_waddr = column;
            energy_wdata = energy[ENERGY_BITS-1:0];
        end
    end

    // Memory ports, all read data registered.
    always_ff @(posedge clk)
    begin
        if (energy_we)
        begin
            energy_mem[energy_waddr] <= energy_wdata;
        end
        e_rd <= energy_mem[scan_col_reg[COL_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept_in && op == OP_WRITE_POINTER
            && {1'b0, row} < 10'(MAX_ROWS) && {1'b0, column} < 10'(MAX_COLUMNS))
        begin
            ptr_mem[{row, column}] <= pointer;
        end
        ptr_rd <= ptr_mem[ptr_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        mark_rd <= mark_mem[mark_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (seam_we)
        begin
            seam_mem[seam_addr] <= seam_wdata;
        end
        seam_rd <= seam_mem[seam_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            sweep_reg <= '0;
            status_reg <= STATUS_DONE;
            colres_reg <= '0;
            retries_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR || state_reg == S_WIPE)
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            else
            begin
                sweep_reg <= '0;
            end
            if (state_next == S_OUT && state_reg != S_OUT)
            begin
                if (state_reg == S_COMMIT_WR)
                begin
                    status_reg <= STATUS_FOUND;
                    colres_reg <= start_reg;
                    retries_reg <= retry_reg;
                end
                else if (state_reg == S_FAIL)
                begin
                    status_reg <= STATUS_RECOMPUTE;
                    colres_reg <= '0;
                    retries_reg <= retry_reg;
                end
                else if (state_reg == S_READ)
                begin
                    status_reg <= STATUS_DONE;
                    colres_reg <= row_ok_reg ? seam_rd : '0;
                    retries_reg <= '0;
                end
                else
                begin
                    status_reg <= STATUS_DONE;
                    colres_reg <= '0;
                    retries_reg <= '0;
                end
            end
        end
    end

    // Scan: address goes out on scan_col_reg, data and mark bit compare in the next cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && accept_in)
        begin
            row_in_reg <= row;
            col_in_reg <= column;
            energy_in_reg <= energy[ENERGY_BITS-1:0];
            row_ok_reg <= {1'b0, row} < 10'(MAX_ROWS);
            retry_reg <= '0;
        end
        if (state_next == S_SCAN && state_reg != S_SCAN)
        begin
            scan_col_reg <= '0;
            best_reg <= '1;
            found_reg <= 1'b0;
            start_reg <= '0;
            if (state_reg == S_TRACE_CHK && retry_reg != 10'(RETRY_MAX))
            begin
                retry_reg <= retry_reg + 1'b1;
            end
        end
        else if (state_reg == S_SCAN)
        begin
            scan_col_reg <= scan_col_reg + 1'b1;
            scan_prev_reg <= scan_col_reg[COL_W-1:0];
            if (scan_col_reg != '0 && !mark_rd[scan_prev_reg] && e_rd < best_reg)
            begin
                best_reg <= e_rd;
                start_reg <= scan_prev_reg;
                found_reg <= 1'b1;
            end
        end
        else if (state_reg == S_SCAN_END)
        begin
            r_reg <= bottom;
            prev_reg <= start_reg;
        end
        else if (state_reg == S_TRACE_CHK && !cur_bad)
        begin
            r_reg <= r_reg - 1'b1;
            prev_reg <= cur;
        end
        else if (state_reg == S_COMMIT_WR)
        begin
            r_reg <= r_reg + 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    // A found seam always reports a column inside the columns in use.
    a_found_col: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_FOUND) |-> ({1'b0, column_res} < 10'(cols_eff)))
        else $error("found seam column out of range");
    // No item is accepted while a result waits to be taken.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while result pending");
    // Retries are only reported by finds.
    a_retry_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_DONE) |-> (retries == '0))
        else $error("retries on non-find item");
`endif
endmodule

### bench/seam_backtrack_checker.sv
// Checker for the seam backtrack engine: predicts each result from the accepted items
// and compares it with the result channel. Depends on sbe_pkg.
`timescale 1ns / 100ps
module seam_backtrack_checker
    import sbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  op,
    input  logic [8:0]  row,
    input  logic [8:0]  column,
    input  logic [31:0] energy,
    input  logic [8:0]  pointer,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [8:0]  column_res,
    input  logic [9:0]  retries,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    output int          mismatches,
    output int          pending
);
    typedef struct packed
    {
        logic [1:0] status;
        logic [8:0] col;
        logic [9:0] retries;
    } seam_answer_t;

    localparam logic [31:0] ENERGY_INF = '1;

    seam_answer_t            answers_due[$];
    logic [31:0]             energy_mem[MAX_COLUMNS];
    logic [8:0]              pointer_mem[MAX_ROWS][MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0]  mark_row[MAX_ROWS];
    logic [8:0]              seam_mem[MAX_ROWS];
    logic [9:0]              rows_cfg;
    logic [9:0]              cols_cfg;

    function automatic int used_count(logic [9:0] v, int maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    task automatic trace_seam(output seam_answer_t res);
        int rows;
        int cols;
        int bottom;
        int tries;
        int c;
        int r;
        int start;
        int prev;
        int cur;
        logic [31:0] best;
        bit found;
        bit collided;
        bit finished;
        begin
            rows = used_count(rows_cfg, MAX_ROWS);
            cols = used_count(cols_cfg, MAX_COLUMNS);
            bottom = rows - 1;
            tries = 0;
            finished = 0;
            res = '0;
            while (!finished)
            begin
                best = ENERGY_INF;
                found = 0;
                start = 0;
                for (c = 0; c < cols; c++)
                begin
                    if (!mark_row[bottom][c] && energy_mem[c] < best)
                    begin
                        best = energy_mem[c];
                        start = c;
                        found = 1;
                    end
                end
                if (!found)
                begin
                    res.status = STATUS_RECOMPUTE;
                    res.retries = 10'(tries);
                    finished = 1;
                end
                else
                begin
                    seam_mem[bottom] = 9'(start);
                    prev = start;
                    collided = 0;
                    r = bottom;
                    while (r > 0 && !collided)
                    begin
                        cur = pointer_mem[r][prev];
                        if (cur >= cols || mark_row[r-1][cur])
                        begin
                            collided = 1;
                        end
                        else
                        begin
                            seam_mem[r-1] = 9'(cur);
                            prev = cur;
                            r = r - 1;
                        end
                    end
                    if (collided)
                    begin
                        energy_mem[start] = ENERGY_INF;
                        if (tries < RETRY_MAX)
                            tries++;
                    end
                    else
                    begin
                        for (c = 0; c < rows; c++)
                            mark_row[c][seam_mem[c]] = 1'b1;
                        res.status = STATUS_FOUND;
                        res.col = 9'(start);
                        res.retries = 10'(tries);
                        finished = 1;
                    end
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        seam_answer_t want;
        seam_answer_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
            begin
                mark_row[i] = '0;
                seam_mem[i] = '0;
            end
            for (int i = 0; i < MAX_COLUMNS; i++)
                energy_mem[i] = '0;
            rows_cfg = 10'd512;
            cols_cfg = 10'd512;
            answers_due.delete();
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROW_COUNT)
                    rows_cfg = cfg_data;
                else
                    cols_cfg = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                want = '0;
                case (op)
                    OP_WRITE_ENERGY: energy_mem[column] = energy;
                    OP_WRITE_POINTER: pointer_mem[row][column] = pointer;
                    OP_CLEAR_MARKS:
                    begin
                        for (int i = 0; i < MAX_ROWS; i++)
                            mark_row[i] = '0;
                    end
                    OP_FIND_SEAM: trace_seam(want);
                    OP_READ_SEAM: want.col = seam_mem[row];
                    default: ;
                endcase
                answers_due.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got.status = status;
                got.col = column_res;
                got.retries = retries;
                if (answers_due.size() == 0)
                begin
                    $display("%0t: result with none expected: status %0d column %0d retries %0d",
                             $time, status, column_res, retries);
                    mismatches++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.col !== want.col)
                    begin
                        $display("%0t: column_res expected %0d actual %0d",
                                 $time, want.col, got.col);
                        mismatches++;
                    end
                    if (got.retries !== want.retries)
                    begin
                        $display("%0t: retries expected %0d actual %0d",
                                 $time, want.retries, got.retries);
                        mismatches++;
                    end
                end
            end
            pending = answers_due.size();
        end
    end
endmodule

### bench/tb_seam_backtrack_engine_top.sv
// Testbench top for the seam backtrack engine: clock, reset, stimulus and verdict.
// Depends on sbe_pkg, seam_backtrack_engine_top and seam_backtrack_checker.
`timescale 1ns / 100ps
module tb_seam_backtrack_engine_top;
    import sbe_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  op;
    logic [8:0]  row;
    logic [8:0]  column;
    logic [31:0] energy;
    logic [8:0]  pointer;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [8:0]  column_res;
    logic [9:0]  retries;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    int          mismatches;
    int          pending;
    int          cycles;
    bit          calm;
    bit          long_hold;
    int          grid_rows;
    int          grid_cols;

    seam_backtrack_engine_top DUT (.*);

    seam_backtrack_checker checker_inst (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("seam_backtrack_engine_top verification failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int n;
        int len;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (4000) @(posedge clk);
                out_stall <= 1'b0;
                long_hold = 0;
            end
            else if (calm)
            begin
                out_stall <= 1'b0;
            end
            else
            begin
                n = $urandom_range(0, 9);
                if (n < 6)
                begin
                    out_stall <= 1'b0;
                    len = $urandom_range(1, 20);
                end
                else
                begin
                    out_stall <= 1'b1;
                    len = (n == 9) ? $urandom_range(20, 200) : $urandom_range(1, 4);
                end
                repeat (len - 1) @(posedge clk);
            end
        end
    end

    // Called after a rising edge; returns after the item is taken and any idle gap.
    task automatic drive_item(int o, int r, int c, logic [31:0] e, int p);
        int n;
        int gap;
        begin
            in_valid <= 1'b1;
            op <= 3'(o);
            row <= 9'(r);
            column <= 9'(c);
            energy <= e;
            pointer <= 9'(p);
            @(posedge clk iff !in_stall);
            n = $urandom_range(0, 19);
            if (calm || n < 12)
                gap = 0;
            else if (n < 18)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(20, 120);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [9:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk iff cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int used_count(logic [9:0] v);
        if (v == 0)
            return 1;
        if (v > 512)
            return 512;
        return v;
    endfunction

    task automatic set_size(logic [9:0] rows_value, logic [9:0] cols_value);
        wait_drained();
        write_reg(CFG_ROW_COUNT, rows_value);
        write_reg(CFG_COLUMN_COUNT, cols_value);
        grid_rows = used_count(rows_value);
        grid_cols = used_count(cols_value);
    endtask

    function automatic logic [31:0] pick_energy();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 3);
            1: return $urandom;
            2: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 50);
        endcase
    endfunction

    // Every energy and pointer a find can read is written before any find.
    task automatic fill_grid();
        for (int c = 0; c < grid_cols; c++)
            drive_item(OP_WRITE_ENERGY, $urandom, c, $urandom_range(0, 40), $urandom);
        for (int r = 1; r < grid_rows; r++)
            for (int c = 0; c < grid_cols; c++)
                drive_item(OP_WRITE_POINTER, r, c, $urandom, $urandom_range(0, grid_cols - 1));
    endtask

    task automatic random_item();
        int k;
        logic [8:0] r;
        logic [8:0] c;
        logic [8:0] p;
        begin
            k = $urandom_range(0, 99);
            r = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, grid_rows - 1));
            c = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(0, grid_cols - 1));
            p = $urandom_range(0, 4) == 0 ? 9'($urandom) : 9'($urandom_range(0, grid_cols - 1));
            if (k < 35)
                drive_item(OP_FIND_SEAM, $urandom, $urandom, $urandom, $urandom);
            else if (k < 50)
                drive_item(OP_READ_SEAM, r, $urandom, $urandom, $urandom);
            else if (k < 70)
                drive_item(OP_WRITE_ENERGY, $urandom, c, pick_energy(), $urandom);
            else if (k < 85)
                drive_item(OP_WRITE_POINTER, r, c, $urandom, p);
            else if (k < 90)
                drive_item(OP_CLEAR_MARKS, $urandom, $urandom, $urandom, $urandom);
            else if (k < 95)
                drive_item(3'($urandom_range(5, 7)), $urandom, $urandom, $urandom, $urandom);
            else
                drive_item(OP_WRITE_ENERGY, $urandom, c, 32'hFFFF_FFFF, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = '0;
        row = '0;
        column = '0;
        energy = '0;
        pointer = '0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        calm = 0;
        long_hold = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: small grid, ties, infinity, bad pointers, odd op codes.
        set_size(10'd4, 10'd5);
        fill_grid();
        drive_item(OP_FIND_SEAM, 0, 0, 0, 0);
        drive_item(OP_READ_SEAM, 0, 0, 0, 0);
        drive_item(OP_READ_SEAM, 3, 0, 0, 0);
        drive_item(OP_READ_SEAM, 9'd511, 0, 0, 0);
        drive_item(OP_WRITE_POINTER, 3, 1, 0, 9'd511);
        drive_item(OP_WRITE_ENERGY, 0, 1, 32'd0, 0);
        drive_item(OP_WRITE_ENERGY, 0, 2, 32'd0, 0);
        drive_item(OP_FIND_SEAM, 0, 0, 0, 0);
        drive_item(OP_WRITE_ENERGY, 9'd511, 9'd511, 32'hFFFF_FFFF, 9'd511);
        drive_item(OP_WRITE_POINTER, 9'd511, 9'd511, 32'hFFFF_FFFF, 9'd511);
        for (int c = 0; c < 5; c++)
            drive_item(OP_WRITE_ENERGY, 0, c, 32'hFFFF_FFFF, 0);
        drive_item(OP_FIND_SEAM, 0, 0, 0, 0);
        drive_item(OP_CLEAR_MARKS, 0, 0, 0, 0);
        drive_item(3'd5, 0, 0, 0, 0);
        drive_item(3'd6, 9'd511, 9'd511, 32'hFFFF_FFFF, 9'd511);
        drive_item(3'd7, 0, 0, 0, 0);

        // One row and one column: a one-pixel seam, then nothing left.
        set_size(10'd0, 10'd0);
        drive_item(OP_WRITE_ENERGY, 0, 0, 32'hFFFF_FFFE, 0);
        drive_item(OP_FIND_SEAM, 0, 0, 0, 0);
        drive_item(OP_FIND_SEAM, 0, 0, 0, 0);
        drive_item(OP_READ_SEAM, 0, 0, 0, 0);

        // Counts above the largest size: only items that read no energy or pointer.
        set_size(10'd1023, 10'd1023);
        drive_item(OP_READ_SEAM, 9'd511, 0, 0, 0);
        drive_item(OP_CLEAR_MARKS, 0, 0, 0, 0);

        // Random phases on small grids.
        for (int ph = 0; ph < 6; ph++)
        begin
            set_size(ph == 5 ? 10'd0 : 10'($urandom_range(1, 10)),
                     ph == 4 ? 10'($urandom_range(513, 1023)) & 10'd7
                             : 10'($urandom_range(1, 10)));
            calm = (ph == 3);
            drive_item(OP_CLEAR_MARKS, 0, 0, 0, 0);
            fill_grid();
            for (int i = 0; i < 28; i++)
            begin
                if (ph == 1 && i == 10)
                    long_hold = 1;
                if (ph == 2 && i == 14)
                    wait_drained();
                random_item();
            end
        end
        calm = 0;
        in_valid <= 1'b0;

        wait_drained();
        repeat (100) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("seam_backtrack_engine_top verification clean");
        else
            $display("seam_backtrack_engine_top verification failed");
        $finish;
    end
endmodule
